>>> rtl/aes_pkg.sv
// aes-128 package: sbox, round constants and round helper functions
`default_nettype none
package aes_pkg;

    localparam int NumRounds = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // register indexes of the configuration port
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    typedef logic [127:0] t_block;

    // byte i of a block, byte 0 most significant
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        get_byte = b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes, shiftrows and (unless last) mixcolumns
    function automatic t_block round_fn(input t_block s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
            if (last) begin
                o[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127-32*c -: 32] = {d0^d1^a1^a2^a3, a0^d1^d2^a2^a3,
                                     a0^a1^d2^d3^a3, d0^a0^a1^a2^d3};
            end
        end
        round_fn = o;
    endfunction

    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] tw;
        tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w[0] = k[127:96] ^ tw;
        w[1] = k[95:64] ^ w[0];
        w[2] = k[63:32] ^ w[1];
        w[3] = k[31:0] ^ w[2];
        next_key = {w[0], w[1], w[2], w[3]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/aes128_block_encrypt.sv
// aes-128 encryption top level: eleven-stage unrolled round pipeline
// One block enters per cycle whenever start is high; busy is always low. The result
// appears with o_done after one register stage for the initial key add, then one per
// round, each round stage doing sbox, shift, mix (not in the last round) and key step.
// The receiver cannot stall; results arrive in order. The user must write key registers
// only while the pipeline is empty (not enforced); each stage has its own round key.
`default_nettype none
module aes128_block_encrypt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_plain_high,
    input  wire  [63:0] i_plain_low,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low
);

    localparam int N = aes_pkg::NumRounds;

    logic [127:0]        r_key;
    aes_pkg::t_block     r_state [N+1];
    aes_pkg::t_block     r_rkey  [N+1];
    logic [N:0]          r_valid;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aes_pkg::CfgKeyHigh: r_key[127:64] <= i_cfg_data;
                aes_pkg::CfgKeyLow:  r_key[63:0]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[N-1:0], start};
        end
    end

    // stage 0: initial key add
    always_ff @(posedge i_clk) begin
        r_state[0] <= {i_plain_high, i_plain_low} ^ r_key;
        r_rkey[0]  <= r_key;
    end

    for (genvar g = 1; g <= N; g++) begin : g_round
        logic [127:0] n_key;
        assign n_key = aes_pkg::next_key(r_rkey[g-1], aes_pkg::RCON[g-1]);
        always_ff @(posedge i_clk) begin
            r_state[g] <= aes_pkg::round_fn(r_state[g-1], g == N) ^ n_key;
            r_rkey[g]  <= n_key;
        end
    end

    assign o_done        = r_valid[N];
    assign o_cipher_high = r_state[N][127:64];
    assign o_cipher_low  = r_state[N][63:0];

endmodule
`default_nettype wire
